// File: src/msdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msdt_pkg: shared types and constants of the multi-slot delay timer
// Holds the slot entry layout, the result layout, request and result codes.
// ----------------------------------------------------------------------------
package msdt_pkg;

	localparam int SLOTS_DEF   = 8;
	localparam int IDLE_DEF    = 65535;
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = 16;

	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_CREATE = 2'd1;
	localparam logic [1:0] FUNC_CANCEL = 2'd2;

	localparam logic [2:0] KIND_NONE      = 3'd0;
	localparam logic [2:0] KIND_EXPIRED   = 3'd1;
	localparam logic [2:0] KIND_CREATED   = 3'd2;
	localparam logic [2:0] KIND_REJECTED  = 3'd3;
	localparam logic [2:0] KIND_CANCELLED = 3'd4;

	// One slot as it sits in the slot memory.
	typedef struct packed {
		logic             notify;
		logic             block;
		logic [CNT_W-1:0] count;
	} entry_t;

	// One result as it travels to the output register.
	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] slot;
		logic       notify;
		logic       wake;
		logic       block;
	} result_t;

endpackage

// File: src/multi_slot_delay_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_delay_timer: one-shot delay slots sharing a millisecond tick
// Channel   Dir  Payload
// s_axis    in   tuser: func; tdata: slot, delay_ticks, want_notify, want_block
// m_axis    out  tuser: kind; tdata: out_slot, notify, wake_task, block_task;
//                tlast: last
//
// A create sweeps the slot memory to choose the current slot, and so does a cancel
// of the current slot; a tick reads the current slot and sweeps only when it
// expires slots. The sweep reads one entry a cycle through the single read port
// while the output does not stall it. Reset clears the slots at once through the
// per-entry valid bits, so no clearing pass follows reset.
// A stalled output holds the sweep only when a second result is ready while
// the output register is still occupied.
// ----------------------------------------------------------------------------
module multi_slot_delay_timer import msdt_pkg::*; #(
	parameter int SLOTS      = SLOTS_DEF,
	parameter int IDLE_COUNT = IDLE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [3:0] slot, [19:4] delay_ticks, [20] want_notify, [21] want_block
	input  logic [23:0] s_axis_tdata,
	// [1:0] func
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] out_slot, [3] notify, [4] wake_task, [5] block_task
	output logic [7:0]  m_axis_tdata,
	// [2:0] kind
	output logic [2:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CUR_W  = $clog2(SLOTS + 1);
	localparam int N_W    = $clog2(MAX_RESULTS + 1);

	localparam logic [CNT_W-1:0]  IDLE_CNT = CNT_W'(IDLE_COUNT);
	localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(IDLE_COUNT - 1);
	localparam logic [CUR_W-1:0]  NONE     = CUR_W'(SLOTS);
	localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(SLOTS - 1);
	localparam logic [N_W-1:0]    N_MAX    = N_W'(MAX_RESULTS);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CANCEL = 3'd1;
	localparam logic [2:0] ST_CHECK  = 3'd2;
	localparam logic [2:0] ST_SCAN0  = 3'd3;
	localparam logic [2:0] ST_SCAN   = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;

	// Request fields.
	logic [1:0]       in_func;
	logic [3:0]       in_slot;
	logic [CNT_W-1:0] in_delay;
	logic             in_wn;
	logic             in_wb;
	logic             in_fire;

	assign in_func  = s_axis_tuser;
	assign in_slot  = s_axis_tdata[3:0];
	assign in_delay = s_axis_tdata[19:4];
	assign in_wn    = s_axis_tdata[20];
	assign in_wb    = s_axis_tdata[21];

	// Control state.
	logic [2:0]       state_q, state_d;
	logic             running_q, running_d;
	logic [CUR_W-1:0] cur_q, cur_d;
	logic [CNT_W-1:0] elapsed_q, elapsed_d;
	logic             pend_v_q, pend_v_d;
	logic             out_v_q, out_v_d;
	logic [N_W-1:0]   n_q, n_d;

	// Working registers of the current request.
	logic [ADDR_W-1:0] slot_q, slot_d;
	logic [CNT_W-1:0]  c_q, c_d;
	logic              sub_q, sub_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0]  best_q, best_d;
	logic [CUR_W-1:0]  who_q, who_d;
	result_t           pend_q, pend_d;
	result_t           out_q, out_d;
	logic              out_last_q, out_last_d;

	// Slot memory port.
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	entry_t            wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	entry_t            rd_data;

	msdt_slot_store #(
		.SLOTS      (SLOTS),
		.IDLE_COUNT (IDLE_COUNT)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// The output register is free when empty or being drained this cycle.
	logic out_free;
	logic out_load;
	assign out_free = !out_v_q || m_axis_tready;

	// Create: range check and the saturating load value.
	logic             slot_ok;
	logic             delay_ok;
	logic [CNT_W-1:0] base;
	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] load_cnt;

	assign slot_ok  = (int'(in_slot) < SLOTS);
	assign delay_ok = (in_delay != '0) && (in_delay < IDLE_CNT);
	assign base     = running_q ? elapsed_q : '0;
	assign sum      = {1'b0, in_delay} + {1'b0, base};
	assign load_cnt = (sum > {1'b0, MAX_CNT}) ? MAX_CNT : sum[CNT_W-1:0];

	// Sweep datapath: one slot per cycle unless stalled, subtracting the fired count on a
	// tick sweep and tracking the lowest-index smallest active count.
	logic             active;
	logic [CNT_W-1:0] rem;
	logic [CNT_W-1:0] nr;
	logic             expire;
	logic [CNT_W-1:0] newrem;
	logic             stall;
	logic             take;
	logic [CUR_W-1:0] who_n;

	assign rem    = rd_data.count;
	assign active = (rem != IDLE_CNT);
	assign nr     = (rem <= c_q) ? '0 : (rem - c_q);
	assign expire = sub_q && active && (nr == '0) && (n_q < N_MAX);
	assign newrem = (!sub_q || !active) ? rem : (expire ? IDLE_CNT : nr);
	assign stall  = expire && pend_v_q && !out_free;
	assign take   = (newrem != IDLE_CNT) && (newrem < best_q);
	assign who_n  = take ? CUR_W'(idx_q) : who_q;

	always_comb begin
		state_d    = state_q;
		running_d  = running_q;
		cur_d      = cur_q;
		elapsed_d  = elapsed_q;
		pend_v_d   = pend_v_q;
		n_d        = n_q;
		slot_d     = slot_q;
		c_d        = c_q;
		sub_d      = sub_q;
		idx_d      = idx_q;
		best_d     = best_q;
		who_d      = who_q;
		pend_d     = pend_q;
		out_d      = out_q;
		out_last_d = out_last_q;
		out_load   = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = rd_data;
		rd_en      = 1'b0;
		rd_addr    = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					slot_d = in_slot[ADDR_W-1:0];
					priority if (in_func == FUNC_CREATE) begin
						if (slot_ok && delay_ok) begin
							// Load the slot now, then choose the current slot.
							wr_en     = 1'b1;
							wr_addr   = in_slot[ADDR_W-1:0];
							wr_data   = '{notify: in_wn, block: in_wb, count: load_cnt};
							elapsed_d = base;
							running_d = 1'b1;
							pend_d    = '{kind: KIND_CREATED, slot: in_slot[2:0],
								notify: 1'b0, wake: 1'b0, block: in_wb};
							pend_v_d  = 1'b1;
							sub_d     = 1'b0;
							state_d   = ST_SCAN0;
						end else begin
							pend_d   = '{kind: KIND_REJECTED, slot: in_slot[2:0],
								notify: 1'b0, wake: 1'b0, block: 1'b0};
							pend_v_d = 1'b1;
							state_d  = ST_FIN;
						end
					end else if (in_func == FUNC_CANCEL) begin
						// Out-of-range cancels vanish without a result.
						if (slot_ok) begin
							rd_en   = 1'b1;
							rd_addr = in_slot[ADDR_W-1:0];
							state_d = ST_CANCEL;
						end
					end else if (in_func == FUNC_TICK) begin
						if (running_q) begin
							elapsed_d = elapsed_q + CNT_W'(1);
							if (cur_q != NONE) begin
								rd_en   = 1'b1;
								rd_addr = cur_q[ADDR_W-1:0];
								state_d = ST_CHECK;
							end
						end
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CANCEL: begin
				wr_en    = 1'b1;
				wr_addr  = slot_q;
				wr_data  = '{notify: rd_data.notify, block: rd_data.block, count: IDLE_CNT};
				pend_d   = '{kind: KIND_CANCELLED, slot: 3'(slot_q),
					notify: 1'b0, wake: rd_data.block, block: 1'b0};
				pend_v_d = 1'b1;
				sub_d    = 1'b0;
				state_d  = (CUR_W'(slot_q) == cur_q) ? ST_SCAN0 : ST_FIN;
			end
			ST_CHECK: begin
				if (elapsed_q >= rem) begin
					elapsed_d = elapsed_q - rem;
					c_d       = rem;
					sub_d     = 1'b1;
					state_d   = ST_SCAN0;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN0: begin
				rd_en   = 1'b1;
				rd_addr = '0;
				idx_d   = '0;
				best_d  = IDLE_CNT;
				who_d   = NONE;
				n_d     = '0;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (!stall) begin
					if (sub_q) begin
						wr_en   = 1'b1;
						wr_addr = idx_q;
						wr_data = '{notify: rd_data.notify, block: rd_data.block,
							count: newrem};
					end
					if (expire) begin
						// An earlier expiry still held is not the last one.
						if (pend_v_q) begin
							out_load   = 1'b1;
							out_d      = pend_q;
							out_last_d = 1'b0;
						end
						pend_d   = '{kind: KIND_EXPIRED, slot: 3'(idx_q),
							notify: rd_data.notify, wake: rd_data.block, block: 1'b0};
						pend_v_d = 1'b1;
						n_d      = n_q + N_W'(1);
					end
					if (take) begin
						best_d = newrem;
					end
					who_d = who_n;
					if (idx_q == LAST_IDX) begin
						cur_d     = who_n;
						running_d = (who_n != NONE);
						state_d   = ST_FIN;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q + ADDR_W'(1);
						idx_d   = idx_q + ADDR_W'(1);
					end
				end
			end
			ST_FIN: begin
				if (!pend_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_d      = pend_q;
					out_last_d = 1'b1;
					pend_v_d   = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (out_load) begin
			out_v_d = 1'b1;
		end else if (m_axis_tready) begin
			out_v_d = 1'b0;
		end else begin
			out_v_d = out_v_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			running_q <= 1'b0;
			cur_q     <= NONE;
			elapsed_q <= '0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
			n_q       <= '0;
		end else begin
			state_q   <= state_d;
			running_q <= running_d;
			cur_q     <= cur_d;
			elapsed_q <= elapsed_d;
			pend_v_q  <= pend_v_d;
			out_v_q   <= out_v_d;
			n_q       <= n_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_q     <= slot_d;
		c_q        <= c_d;
		sub_q      <= sub_d;
		idx_q      <= idx_d;
		best_q     <= best_d;
		who_q      <= who_d;
		pend_q     <= pend_d;
		out_q      <= out_d;
		out_last_q <= out_last_d;
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = {2'b00, out_q.block, out_q.wake, out_q.notify, out_q.slot};
	assign m_axis_tlast  = out_last_q;

	// A new request is taken only after the held result has been flushed.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !pend_v_q)
		else $error("request accepted while a result is still held");

	// A stopped timer never names a current slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (cur_q == NONE))
		else $error("current slot set while timer is stopped");

	// The output register is never overwritten before it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten");

	// The expiry count of one tick stays within its limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= N_MAX)
		else $error("too many expiries in one tick");

endmodule

// File: src/msdt_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msdt_slot_store: slot memory of the delay timer
// One write port, one registered read port, a valid bit per entry so that an
// entry never written since reset reads as an idle slot.
// ----------------------------------------------------------------------------
module msdt_slot_store import msdt_pkg::*; #(
	parameter int SLOTS      = SLOTS_DEF,
	parameter int IDLE_COUNT = IDLE_DEF,
	localparam int ADDR_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  entry_t            wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output entry_t            rd_data
);

	localparam entry_t RESET_ENTRY = '{notify: 1'b0, block: 1'b0,
		count: CNT_W'(IDLE_COUNT)};

	entry_t             mem [SLOTS];
	logic [SLOTS-1:0]   vld_q;
	entry_t             rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A read and a write of the same entry in one cycle return the old data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= vld_q[rd_addr] ? mem[rd_addr] : RESET_ENTRY;
		end
	end

	assign rd_data = rd_data_q;

endmodule
